[rtl/rerj_pkg.sv]
`default_nettype none
package rerj_pkg;

  // Fixed-point format and datapath widths.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CFG_IDX_W = 4;

  // Divider: quotient bits produced one per stage, plus an overflow bit.
  localparam int DIV_QW = DATA_W + 1;
  localparam int DIV_STEPS = DIV_QW;
  localparam int DIV_HI_W = PROD_W - DIV_QW;
  localparam int NUM_DIV_LANES = 3;

  // Lane roles in the first divider bank.
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_G = 2;

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((64'sd1 <<< (DATA_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(64'sd1 <<< (DATA_W - 1)));

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X     = 4'd0,
    REG_FOCAL_Y     = 4'd1,
    REG_CENTER_X    = 4'd2,
    REG_CENTER_Y    = 4'd3,
    REG_CURVE_QUAD  = 4'd4,
    REG_CURVE_LIN   = 4'd5,
    REG_CURVE_CONST = 4'd6,
    REG_LANE_SLOPE  = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    word_t focal_x;
    word_t focal_y;
    word_t center_x;
    word_t center_y;
    word_t curve_quad;
    word_t curve_lin;
    word_t curve_const;
    word_t lane_slope;
  } cfg_regs_t;

  // Sideband that travels alongside the divider lanes.
  typedef struct packed {
    logic              bad;
    logic [DATA_W-1:0] den;
    word_t             xr;
    word_t             yr;
    word_t             gx;
  } div_side_t;

  typedef logic [NUM_DIV_LANES-1:0][PROD_W-1:0] div_num_t;
  typedef logic [NUM_DIV_LANES-1:0][DATA_W-1:0] div_quo_t;

  // Saturate an exact wide value to the signed 32-bit range.
  function automatic word_t sat32(input logic signed [PROD_W-1:0] a);
    if (a > SAT_MAX) begin
      return word_t'(SAT_MAX);
    end else if (a < SAT_MIN) begin
      return word_t'(SAT_MIN);
    end
    return word_t'(a);
  endfunction

  // Fixed-point product, floor rounding, saturated.
  function automatic word_t qmul(input word_t a, input word_t b);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return sat32(p >>> FRAC_BITS);
  endfunction

endpackage
`default_nettype wire

[rtl/rerj_if.sv]
`default_nettype none
// Point channel: one item is one 3D point.
interface rerj_in_if;
  logic                  valid;
  logic                  ready;
  rerj_pkg::word_t       point_x;
  rerj_pkg::word_t       point_y;
  rerj_pkg::word_t       point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

// Result channel: one item per point.
interface rerj_out_if;
  logic                  valid;
  logic                  ready;
  rerj_pkg::word_t       residual;
  rerj_pkg::word_t       grad_x;
  rerj_pkg::word_t       grad_z;
  logic                  depth_invalid;
  modport source(output valid, residual, grad_x, grad_z, depth_invalid, input ready);
  modport sink(input valid, residual, grad_x, grad_z, depth_invalid, output ready);
endinterface
`default_nettype wire

[rtl/road_edge_residual_jacobian_unit.sv]
// Channel      Role     Handshake     Payload
// point_in     sink     valid/ready   point_x, point_y, point_z
// result_out   source   valid/ready   residual, grad_x, grad_z, depth_invalid
// cfg          write    cfg_we        cfg_index, cfg_data
//
// One item enters per cycle unless the pipeline holds; results leave in the order
// their points were taken, after two 35-stage dividers in series (projection, then the
// z partials), one quotient bit per restoring step, plus the multiply stages around them.
// Reset is synchronous and clears all valid bits and the configuration registers.
// The whole pipeline holds while a result waits and result_out.ready is low.
`default_nettype none
module road_edge_residual_jacobian_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rerj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rerj_pkg::DATA_W-1:0]    cfg_data,
  rerj_in_if.sink                             point_in,
  rerj_out_if.source                          result_out
);

  rerj_pkg::cfg_regs_t  regs;
  logic                 en;

  logic                 f_valid;
  rerj_pkg::div_num_t   f_num;
  rerj_pkg::div_side_t  f_side;

  logic                 d1_valid;
  rerj_pkg::div_quo_t   d1_quo;
  rerj_pkg::div_side_t  d1_side;

  rerj_pkg::div_num_t   d2_num;
  rerj_pkg::div_side_t  d2_side_in;

  logic                 d2_valid;
  rerj_pkg::div_quo_t   d2_quo;
  rerj_pkg::div_side_t  d2_side;

  // Global advance: move when the output register is empty or being taken.
  assign en = !result_out.valid || result_out.ready;
  assign point_in.ready = en;

  rerj_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .regs
  );

  rerj_front u_front (
    .clk, .rst, .en,
    .in_valid (point_in.valid),
    .point_x  (point_in.point_x),
    .point_y  (point_in.point_y),
    .point_z  (point_in.point_z),
    .regs,
    .out_valid(f_valid),
    .out_num  (f_num),
    .out_side (f_side)
  );

  // First bank: X/Z, Y/Z and the x gradient.
  rerj_div u_div_proj (
    .clk, .rst, .en,
    .in_valid (f_valid),
    .in_num   (f_num),
    .in_side  (f_side),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // Second bank: projected coordinates divided by depth once more.
  always_comb begin
    d2_num                      = '0;
    d2_num[rerj_pkg::LANE_X]    = rerj_pkg::PROD_W'($signed(d1_quo[rerj_pkg::LANE_X]))
                                  <<< rerj_pkg::FRAC_BITS;
    d2_num[rerj_pkg::LANE_Y]    = rerj_pkg::PROD_W'($signed(d1_quo[rerj_pkg::LANE_Y]))
                                  <<< rerj_pkg::FRAC_BITS;
    d2_side_in                  = d1_side;
    d2_side_in.xr               = d1_quo[rerj_pkg::LANE_X];
    d2_side_in.yr               = d1_quo[rerj_pkg::LANE_Y];
    d2_side_in.gx               = d1_quo[rerj_pkg::LANE_G];
  end

  rerj_div u_div_part (
    .clk, .rst, .en,
    .in_valid (d1_valid),
    .in_num   (d2_num),
    .in_side  (d2_side_in),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  rerj_back u_back (
    .clk, .rst, .en,
    .in_valid (d2_valid),
    .in_quo   (d2_quo),
    .in_side  (d2_side),
    .regs,
    .result_out
  );

endmodule
`default_nettype wire

[rtl/rerj_cfg.sv]
`default_nettype none
module rerj_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rerj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rerj_pkg::DATA_W-1:0]    cfg_data,
  output rerj_pkg::cfg_regs_t                 regs
);

  // Register file; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      unique case (rerj_pkg::cfg_idx_t'(cfg_index))
        rerj_pkg::REG_FOCAL_X:     regs.focal_x     <= cfg_data;
        rerj_pkg::REG_FOCAL_Y:     regs.focal_y     <= cfg_data;
        rerj_pkg::REG_CENTER_X:    regs.center_x    <= cfg_data;
        rerj_pkg::REG_CENTER_Y:    regs.center_y    <= cfg_data;
        rerj_pkg::REG_CURVE_QUAD:  regs.curve_quad  <= cfg_data;
        rerj_pkg::REG_CURVE_LIN:   regs.curve_lin   <= cfg_data;
        rerj_pkg::REG_CURVE_CONST: regs.curve_const <= cfg_data;
        rerj_pkg::REG_LANE_SLOPE:  regs.lane_slope  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/rerj_front.sv]
`default_nettype none
module rerj_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  rerj_pkg::word_t           point_x,
  input  rerj_pkg::word_t           point_y,
  input  rerj_pkg::word_t           point_z,
  input  rerj_pkg::cfg_regs_t       regs,
  output logic                      out_valid,
  output rerj_pkg::div_num_t        out_num,
  output rerj_pkg::div_side_t       out_side
);

  logic bad;

  assign bad = (point_z <= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Exact numerators for the projection and the x gradient.
  always_ff @(posedge clk) begin
    if (en) begin
      out_num[rerj_pkg::LANE_X] <= rerj_pkg::PROD_W'(regs.focal_x) *
                                   rerj_pkg::PROD_W'(point_x);
      out_num[rerj_pkg::LANE_Y] <= rerj_pkg::PROD_W'(regs.focal_y) *
                                   rerj_pkg::PROD_W'(point_y);
      out_num[rerj_pkg::LANE_G] <= rerj_pkg::PROD_W'(regs.focal_x) <<< rerj_pkg::FRAC_BITS;
      out_side.bad <= bad;
      out_side.den <= bad ? rerj_pkg::DATA_W'(1) : point_z;
      out_side.xr  <= '0;
      out_side.yr  <= '0;
      out_side.gx  <= '0;
    end
  end

endmodule
`default_nettype wire

[rtl/rerj_div.sv]
`default_nettype none
module rerj_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  rerj_pkg::div_num_t        in_num,
  input  rerj_pkg::div_side_t       in_side,
  output logic                      out_valid,
  output rerj_pkg::div_quo_t        out_quo,
  output rerj_pkg::div_side_t       out_side
);

  localparam int L  = rerj_pkg::NUM_DIV_LANES;
  localparam int N  = rerj_pkg::DIV_STEPS;
  localparam int QW = rerj_pkg::DIV_QW;
  localparam int DW = rerj_pkg::DATA_W;

  // Per-stage state: stage 0 is the prepared operand, stage k holds k quotient bits.
  logic [N:0]                 s_valid;
  logic [N:0][L-1:0]          s_neg;
  logic [N:0][L-1:0]          s_ovf;
  logic [N:0][L-1:0][DW-1:0]  s_rem;
  logic [N:0][L-1:0][QW-1:0]  s_lo;
  logic [N:0][L-1:0][QW-1:0]  s_q;
  rerj_pkg::div_side_t        s_side [N+1];

  logic [L-1:0][rerj_pkg::PROD_W-1:0] mag;
  logic [L-1:0][DW-1:0]               hi;

  // Magnitude of each numerator and its upper part.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      mag[l] = in_num[l][rerj_pkg::PROD_W-1] ? -in_num[l] : in_num[l];
      hi[l]  = DW'(mag[l][rerj_pkg::PROD_W-1:QW]);
    end
  end

  // Operand preparation; a quotient that needs more than QW bits saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        s_neg[0][l] <= in_num[l][rerj_pkg::PROD_W-1];
        s_ovf[0][l] <= (hi[l] >= in_side.den);
        s_rem[0][l] <= (hi[l] >= in_side.den) ? '0 : hi[l];
        s_lo[0][l]  <= mag[l][QW-1:0];
        s_q[0][l]   <= '0;
      end
      s_side[0] <= in_side;
    end
  end

  // One restoring step per stage.
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [L-1:0][DW-1:0] trial;
    logic [L-1:0]         take;

    always_comb begin
      for (int l = 0; l < L; l++) begin
        trial[l] = {s_rem[k-1][l][DW-2:0], s_lo[k-1][l][QW-1]};
        take[l]  = (trial[l] >= s_side[k-1].den);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[k] <= 1'b0;
      end else if (en) begin
        s_valid[k] <= s_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < L; l++) begin
          s_neg[k][l] <= s_neg[k-1][l];
          s_ovf[k][l] <= s_ovf[k-1][l];
          s_rem[k][l] <= take[l] ? trial[l] - s_side[k-1].den : trial[l];
          s_lo[k][l]  <= {s_lo[k-1][l][QW-2:0], 1'b0};
          s_q[k][l]   <= {s_q[k-1][l][QW-2:0], take[l]};
        end
        s_side[k] <= s_side[k-1];
      end
    end
  end

  // Apply the sign and saturate to the signed 32-bit range.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        if (s_neg[N][l]) begin
          if (s_ovf[N][l] || s_q[N][l] > (QW'(1) << (DW - 1))) begin
            out_quo[l] <= DW'(rerj_pkg::SAT_MIN);
          end else begin
            out_quo[l] <= DW'(-s_q[N][l]);
          end
        end else begin
          if (s_ovf[N][l] || s_q[N][l] > ((QW'(1) << (DW - 1)) - QW'(1))) begin
            out_quo[l] <= DW'(rerj_pkg::SAT_MAX);
          end else begin
            out_quo[l] <= DW'(s_q[N][l]);
          end
        end
      end
      out_side <= s_side[N];
    end
  end

endmodule
`default_nettype wire

[rtl/rerj_back.sv]
`default_nettype none
module rerj_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  rerj_pkg::div_quo_t        in_quo,
  input  rerj_pkg::div_side_t       in_side,
  input  rerj_pkg::cfg_regs_t       regs,
  rerj_out_if.source                result_out
);

  localparam int PW = rerj_pkg::PROD_W;

  logic [3:0] v;

  // Stage 0: pixel coordinates and the z partials.
  logic            p0_bad;
  rerj_pkg::word_t p0_u, p0_v, p0_gx, p0_pu, p0_pv;
  // Stage 1: products of v.
  logic            p1_bad;
  rerj_pkg::word_t p1_u, p1_gx, p1_pu, p1_pv, p1_vv, p1_qav, p1_qbv, p1_dv;
  // Stage 2: second-level products and dL/dv.
  logic            p2_bad;
  rerj_pkg::word_t p2_u, p2_gx, p2_pu, p2_pv, p2_qbv, p2_qavv, p2_sldv, p2_dldv;
  // Stage 3: curve value and the v share of the z gradient.
  logic            p3_bad;
  rerj_pkg::word_t p3_u, p3_gx, p3_pu, p3_sldv, p3_poly, p3_dlpv;

  rerj_pkg::word_t loss, gz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      result_out.valid <= 1'b0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
      result_out.valid <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_bad <= in_side.bad;
      p0_u   <= rerj_pkg::sat32(PW'(in_side.xr) + PW'(regs.center_x));
      p0_v   <= rerj_pkg::sat32(PW'(in_side.yr) + PW'(regs.center_y));
      p0_gx  <= in_side.gx;
      p0_pu  <= rerj_pkg::sat32(-PW'($signed(in_quo[rerj_pkg::LANE_X])));
      p0_pv  <= rerj_pkg::sat32(-PW'($signed(in_quo[rerj_pkg::LANE_Y])));

      p1_bad <= p0_bad;
      p1_u   <= p0_u;
      p1_gx  <= p0_gx;
      p1_pu  <= p0_pu;
      p1_pv  <= p0_pv;
      p1_vv  <= rerj_pkg::qmul(p0_v, p0_v);
      p1_qav <= rerj_pkg::qmul(regs.curve_quad, p0_v);
      p1_qbv <= rerj_pkg::qmul(regs.curve_lin, p0_v);
      p1_dv  <= rerj_pkg::sat32(PW'(p0_v) - PW'(regs.center_y));

      p2_bad  <= p1_bad;
      p2_u    <= p1_u;
      p2_gx   <= p1_gx;
      p2_pu   <= p1_pu;
      p2_pv   <= p1_pv;
      p2_qbv  <= p1_qbv;
      p2_qavv <= rerj_pkg::qmul(regs.curve_quad, p1_vv);
      p2_sldv <= rerj_pkg::qmul(regs.lane_slope, p1_dv);
      p2_dldv <= rerj_pkg::sat32(PW'(regs.lane_slope) - (PW'(p1_qav) <<< 1) -
                                 PW'(regs.curve_lin));

      p3_bad  <= p2_bad;
      p3_u    <= p2_u;
      p3_gx   <= p2_gx;
      p3_pu   <= p2_pu;
      p3_sldv <= p2_sldv;
      p3_poly <= rerj_pkg::sat32(PW'(p2_qavv) + PW'(p2_qbv) + PW'(regs.curve_const));
      p3_dlpv <= rerj_pkg::qmul(p2_dldv, p2_pv);
    end
  end

  // Final loss and z gradient.
  assign loss = rerj_pkg::sat32(PW'(p3_u) + PW'(p3_sldv) - PW'(p3_poly));
  assign gz   = rerj_pkg::sat32(PW'(p3_pu) + PW'(p3_dlpv));

  // Output register: bad depth or negative loss give zero fields.
  always_ff @(posedge clk) begin
    if (en) begin
      result_out.depth_invalid <= p3_bad;
      if (p3_bad || loss < 0) begin
        result_out.residual <= '0;
        result_out.grad_x   <= '0;
        result_out.grad_z   <= '0;
      end else begin
        result_out.residual <= loss;
        result_out.grad_x   <= p3_gx;
        result_out.grad_z   <= gz;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rerj_chk.sv]
`default_nettype none
module rerj_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [rerj_pkg::DATA_W-1:0] residual,
  input wire logic [rerj_pkg::DATA_W-1:0] grad_x,
  input wire logic [rerj_pkg::DATA_W-1:0] grad_z,
  input wire logic                        depth_invalid
);

  // A waiting result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(residual) && $stable(grad_x) &&
      $stable(grad_z) && $stable(depth_invalid))
    else $error("result changed while stalled");

  // Bad depth gives all-zero values.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_invalid |-> residual == '0 && grad_x == '0 && grad_z == '0)
    else $error("nonzero result for bad depth");

  // The residual is clamped at zero.
  a_relu: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !residual[rerj_pkg::DATA_W-1])
    else $error("negative residual");

  // Points are taken whenever the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  // No result right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind road_edge_residual_jacobian_unit rerj_chk u_rerj_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (point_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .residual     (result_out.residual),
  .grad_x       (result_out.grad_x),
  .grad_z       (result_out.grad_z),
  .depth_invalid(result_out.depth_invalid)
);
`default_nettype wire

[tb/rerj_checker.sv]
`default_nettype none
// Watches the point and result channels and the register write port, keeps its
// own copy of the registers, predicts every result and compares it in order.
module rerj_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rerj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rerj_pkg::DATA_W-1:0]    cfg_data,
  rerj_in_if                                  point_mon,
  rerj_out_if                                 result_mon,
  output int                                  fail_count,
  output int                                  results_pending,
  output int                                  results_seen
);
  import rerj_pkg::*;

  typedef struct packed {
    word_t residual;
    word_t grad_x;
    word_t grad_z;
    logic  depth_invalid;
  } edge_result_t;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  cfg_regs_t    shadow_regs;
  edge_result_t expected_results[$];

  // Clamp an exact value to the signed 32-bit range.
  function automatic longint clamp_word(input longint a);
    if (a > WORD_MAX) begin
      return WORD_MAX;
    end
    if (a < WORD_MIN) begin
      return WORD_MIN;
    end
    return a;
  endfunction

  // Fixed-point product with floor rounding.
  function automatic longint fix_mul(input longint a, input longint b);
    return clamp_word((a * b) >>> FRAC_BITS);
  endfunction

  // Quotient of an exact numerator, truncated toward zero.
  function automatic longint fix_div(input longint n, input longint d);
    return clamp_word(n / d);
  endfunction

  // Projection, edge loss and its x/z gradients for one point.
  function automatic edge_result_t project_edge_loss(input cfg_regs_t c, input word_t px,
                                                      input word_t py, input word_t pz);
    edge_result_t r;
    longint       unit_val, x_ratio, y_ratio, u, v, poly, loss, slope_v, part_uz, part_vz;
    r = '0;
    unit_val = 64'sd1 <<< FRAC_BITS;
    if (pz <= 0) begin
      r.depth_invalid = 1'b1;
      return r;
    end
    x_ratio = fix_div(longint'(c.focal_x) * longint'(px), longint'(pz));
    y_ratio = fix_div(longint'(c.focal_y) * longint'(py), longint'(pz));
    u = clamp_word(x_ratio + longint'(c.center_x));
    v = clamp_word(y_ratio + longint'(c.center_y));
    poly = clamp_word(fix_mul(c.curve_quad, fix_mul(v, v)) + fix_mul(c.curve_lin, v)
                      + longint'(c.curve_const));
    loss = clamp_word(u + fix_mul(c.lane_slope, clamp_word(v - longint'(c.center_y))) - poly);
    // A negative loss gives an all-zero result.
    if (loss < 0) begin
      return r;
    end
    slope_v = clamp_word(longint'(c.lane_slope) - 2 * fix_mul(c.curve_quad, v)
                         - longint'(c.curve_lin));
    part_uz = clamp_word(-fix_div(x_ratio * unit_val, longint'(pz)));
    part_vz = clamp_word(-fix_div(y_ratio * unit_val, longint'(pz)));
    r.residual = word_t'(loss);
    r.grad_x   = word_t'(fix_div(longint'(c.focal_x) * unit_val, longint'(pz)));
    r.grad_z   = word_t'(clamp_word(part_uz + fix_mul(slope_v, part_vz)));
    return r;
  endfunction

  assign results_pending = expected_results.size();

  always @(posedge clk) begin
    edge_result_t got, want;
    if (rst) begin
      shadow_regs <= '0;
      expected_results.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (point_mon.valid && point_mon.ready) begin
        expected_results.push_back(project_edge_loss(shadow_regs, point_mon.point_x,
                                                     point_mon.point_y, point_mon.point_z));
      end
      if (result_mon.valid && result_mon.ready) begin
        got = '{result_mon.residual, result_mon.grad_x, result_mon.grad_z,
                result_mon.depth_invalid};
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result res=%h gx=%h gz=%h inv=%b", $realtime,
                   got.residual, got.grad_x, got.grad_z, got.depth_invalid);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.residual !== want.residual || got.grad_x !== want.grad_x ||
              got.grad_z !== want.grad_z || got.depth_invalid !== want.depth_invalid) begin
            $display("%0t: mismatch expected res=%h gx=%h gz=%h inv=%b", $realtime,
                     want.residual, want.grad_x, want.grad_z, want.depth_invalid);
            $display("%0t:          actual   res=%h gx=%h gz=%h inv=%b", $realtime,
                     got.residual, got.grad_x, got.grad_z, got.depth_invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Register writes must land only while the block is idle; nothing here enforces it.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_FOCAL_X:     shadow_regs.focal_x     <= cfg_data;
          REG_FOCAL_Y:     shadow_regs.focal_y     <= cfg_data;
          REG_CENTER_X:    shadow_regs.center_x    <= cfg_data;
          REG_CENTER_Y:    shadow_regs.center_y    <= cfg_data;
          REG_CURVE_QUAD:  shadow_regs.curve_quad  <= cfg_data;
          REG_CURVE_LIN:   shadow_regs.curve_lin   <= cfg_data;
          REG_CURVE_CONST: shadow_regs.curve_const <= cfg_data;
          REG_LANE_SLOPE:  shadow_regs.lane_slope  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
  import rerj_pkg::*;

  localparam word_t WORD_HI = 32'sh7fffffff;
  localparam word_t WORD_LO = 32'sh80000000;
  localparam int    NUM_REGS = 8;
  localparam int    DRAIN_CYCLES = 100;
  localparam int    LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  int fail_count, results_pending, results_seen;
  int points_sent = 0;
  int phases_run = 0;

  rerj_in_if  point_ch ();
  rerj_out_if result_ch ();

  road_edge_residual_jacobian_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_in(point_ch.sink), .result_out(result_ch.source)
  );

  rerj_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_mon(point_ch), .result_mon(result_ch), .fail_count(fail_count),
    .results_pending(results_pending), .results_seen(results_seen)
  );

  always #1 clk = ~clk;

  initial begin
    point_ch.valid = 1'b0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    point_ch.point_z = '0;
    result_ch.ready = 1'b0;
  end

  // Write one register at the next rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_config(input cfg_regs_t c);
    write_reg(REG_FOCAL_X, c.focal_x);
    write_reg(REG_FOCAL_Y, c.focal_y);
    write_reg(REG_CENTER_X, c.center_x);
    write_reg(REG_CENTER_Y, c.center_y);
    write_reg(REG_CURVE_QUAD, c.curve_quad);
    write_reg(REG_CURVE_LIN, c.curve_lin);
    write_reg(REG_CURVE_CONST, c.curve_const);
    write_reg(REG_LANE_SLOPE, c.lane_slope);
    // An index past the last register must be ignored.
    write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), word_t'($urandom));
    phases_run++;
  endtask

  // Offer one point and hold it until it is taken; leaves at a falling edge.
  task automatic send_point(input word_t x, input word_t y, input word_t z);
    point_ch.valid = 1'b1;
    point_ch.point_x = x;
    point_ch.point_y = y;
    point_ch.point_z = z;
    do @(posedge clk); while (!point_ch.ready);
    points_sent++;
    @(negedge clk);
  endtask

  // Let the pipeline empty before the registers change.
  task automatic wait_idle();
    point_ch.valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic word_t signed_span(input int unsigned span);
    return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
  endfunction

  // A camera set up like a real one, with a mild random edge curve.
  function automatic cfg_regs_t camera_config();
    cfg_regs_t c;
    c.focal_x     = word_t'($urandom_range(200, 1000)) <<< 16;
    c.focal_y     = word_t'($urandom_range(200, 1000)) <<< 16;
    c.center_x    = word_t'($urandom_range(200, 400)) <<< 16;
    c.center_y    = word_t'($urandom_range(150, 300)) <<< 16;
    c.curve_quad  = signed_span(200);
    c.curve_lin   = signed_span(32'h0001_0000);
    c.curve_const = word_t'($urandom_range(0, 640)) <<< 16;
    c.lane_slope  = signed_span(32'h0002_0000);
    return c;
  endfunction

  // Mostly plausible points in front of the camera, plus noise and bad depths.
  task automatic send_random_points(input int count);
    int sel, burst;
    word_t x, y, z;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && count > 0) begin
        sel = $urandom_range(0, 99);
        x = signed_span(32'h0014_0000);
        y = signed_span(32'h000a_0000);
        z = word_t'($urandom_range(32'h0000_8000, 32'h003c_0000));
        if (sel >= 90) begin
          x = word_t'($urandom);
          y = word_t'($urandom);
          z = word_t'($urandom);
        end else if (sel >= 80) begin
          z = ($urandom_range(0, 1) != 0) ? word_t'(0) : -word_t'($urandom_range(1, 32'h7fff_ffff));
        end else if (sel >= 75) begin
          x = ($urandom_range(0, 1) != 0) ? WORD_HI : WORD_LO;
          y = ($urandom_range(0, 1) != 0) ? WORD_HI : WORD_LO;
          z = ($urandom_range(0, 1) != 0) ? word_t'(1) : WORD_HI;
        end
        send_point(x, y, z);
        burst--;
        count--;
      end
      if ($urandom_range(0, 1) != 0) begin
        point_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  // Receiver: random stalls, free-running stretches, and one long hold-off.
  initial begin
    bit held_long;
    int stretch;
    held_long = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_long && points_sent >= 300) begin
        held_long = 1'b1;
        result_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stretch = $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) begin
        result_ch.ready = 1'b1;
        repeat (stretch) @(negedge clk);
      end else begin
        repeat (stretch) begin
          result_ch.ready = ($urandom_range(0, 3) != 0);
          @(negedge clk);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    cfg_regs_t c;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed points under a realistic camera.
    c = camera_config();
    c.curve_const = 32'sh0140_0000;
    load_config(c);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh000a_0000);
    send_point(32'shfff6_0000, 32'sh0002_0000, 32'sh0005_0000);
    send_point(32'sh0014_0000, 32'shfffe_0000, 32'sh0002_0000);
    send_point(32'shffec_0000, 32'sh0000_0000, 32'sh0001_0000);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'shffff_ffff);
    send_point(WORD_HI, WORD_HI, WORD_LO);
    send_point(WORD_HI, WORD_HI, 32'sh0000_0001);
    send_point(WORD_LO, WORD_LO, 32'sh0000_0001);
    send_point(WORD_HI, WORD_LO, WORD_HI);
    send_point(WORD_LO, WORD_HI, WORD_HI);
    send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0001);
    send_point(32'shffff_ffff, 32'shffff_ffff, 32'sh0001_0000);
    send_point(32'sh0000_0001, 32'sh0000_0001, WORD_HI);
    send_point(32'sh0050_0000, 32'sh0000_0000, 32'sh0001_0000);
    send_point(32'shffb0_0000, 32'sh0000_0000, 32'sh0001_0000);
    send_random_points(600);
    wait_idle();

    // Every register at its largest value.
    c = '{default: WORD_HI};
    load_config(c);
    send_random_points(150);
    wait_idle();

    // Every register at its most negative value.
    c = '{default: WORD_LO};
    load_config(c);
    send_random_points(150);
    wait_idle();

    // Registers anywhere in range.
    c = '{word_t'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom),
          word_t'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom)};
    load_config(c);
    send_random_points(250);
    wait_idle();

    // Another camera, with zero registers left at reset values nowhere.
    c = camera_config();
    load_config(c);
    send_random_points(450);
    wait_idle();

    $display("Ran %0d points across %0d register settings; %0d results checked.",
             points_sent, phases_run, results_seen);
    $display("Covered bad depths, negative losses, saturation and a long output stall.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/rerj_pkg.sv
rtl/rerj_if.sv
rtl/rerj_cfg.sv
rtl/rerj_front.sv
rtl/rerj_div.sv
rtl/rerj_back.sv
rtl/road_edge_residual_jacobian_unit.sv
rtl/rerj_chk.sv
tb/rerj_checker.sv
tb/tb_top.sv
